@@ hdl/fsa_pkg.sv @@
// shared types and codes for the free segment allocator
package fsa_pkg;

	localparam int unsigned LEN_W  = 21;
	localparam int unsigned OUT_W  = 20;
	localparam int unsigned REG_W  = 21;

	localparam logic CMD_ALLOC = 1'b0;
	localparam logic CMD_FREE  = 1'b1;

	localparam logic [1:0] FIT_BEST  = 2'd0;
	localparam logic [1:0] FIT_WORST = 2'd1;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_NOSPACE = 2'd1;
	localparam logic [1:0] ST_BADARG  = 2'd2;
	localparam logic [1:0] ST_FULL    = 2'd3;

	// one request
	typedef struct packed {
		logic             cmd;
		logic [LEN_W-1:0] req_size;
		logic [1:0]       fit_style;
		logic [OUT_W-1:0] free_addr;
		logic [LEN_W-1:0] free_len;
	} req_t;

	// one result
	typedef struct packed {
		logic [OUT_W-1:0] grant_addr;
		logic [1:0]       status;
	} rsp_t;

	// table operation broadcast to every cell
	typedef enum logic [2:0] {
		OP_HOLD   = 3'b001,
		OP_SHIFTL = 3'b010,
		OP_SHIFTR = 3'b100
	} op_t;

endpackage

@@ hdl/fsa_cell.sv @@
// one table slot: holds a segment, can take its neighbour's entry or a new one
module fsa_cell #(
	parameter int unsigned AW = 20,
	parameter logic [fsa_pkg::LEN_W-1:0] RST_LEN = '0
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  fsa_pkg::op_t            op,
	input  logic                    load,
	input  logic                    from_left,
	input  logic [AW-1:0]           new_start,
	input  logic [fsa_pkg::LEN_W-1:0] new_len,
	input  logic [AW-1:0]           left_start,
	input  logic [fsa_pkg::LEN_W-1:0] left_len,
	input  logic [AW-1:0]           right_start,
	input  logic [fsa_pkg::LEN_W-1:0] right_len,
	output logic [AW-1:0]           start_q,
	output logic [fsa_pkg::LEN_W-1:0] len_q
);
	import fsa_pkg::*;

	// slot register update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q <= '0;
			len_q   <= RST_LEN;
		end else if (load) begin
			start_q <= new_start;
			len_q   <= new_len;
		end else if (op == OP_SHIFTL && !from_left) begin
			start_q <= right_start;
			len_q   <= right_len;
		end else if (op == OP_SHIFTR && from_left) begin
			start_q <= left_start;
			len_q   <= left_len;
		end
	end
endmodule

@@ hdl/free_segment_allocator.sv @@
// free segment allocator: chain of table cells and a scanning controller
//
// channel  | signals                         | handshake
// request  | start, busy, req                | taken when start && !busy
// result   | done, rsp                       | one-cycle strobe, no stall
// config   | cfg_we, cfg_data                | written when cfg_we, idle and cfg_data != 0
//
// every request scans the table one cell per cycle over the entries held,
// then passes through an update state and an output state before the
// strobe. reset loads one segment of PAGE-HEADER bytes. results cannot be
// held off; busy stays high until the cycle of the strobe.
module free_segment_allocator #(
	parameter int unsigned SEGMENTS  = 16,
	parameter int unsigned HEADER    = 16,
	parameter int unsigned PAGE      = 4096,
	parameter int unsigned ADDR_BITS = 20
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  fsa_pkg::req_t              req,
	output logic                       busy,
	output logic                       done,
	output fsa_pkg::rsp_t              rsp,
	input  logic                       cfg_we,
	input  logic [fsa_pkg::REG_W-1:0]  cfg_data
);
	import fsa_pkg::*;

	localparam int unsigned IW = $clog2(SEGMENTS);
	localparam int unsigned CW = $clog2(SEGMENTS + 1);
	localparam int unsigned AW = ADDR_BITS;
	localparam int unsigned PB = $clog2(PAGE);
	localparam int unsigned WW = (AW > REG_W ? AW : REG_W) + 2;

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_SCAN = 4'b0010,
		S_UPD  = 4'b0100,
		S_DONE = 4'b1000
	} state_t;

	state_t state_q;
	req_t   req_q;
	logic [CW-1:0] cnt_q;
	logic [CW-1:0] idx_q;
	logic          found_q;
	logic [IW-1:0] pick_q;
	logic [LEN_W-1:0] plen_q;
	logic [CW-1:0] pos_q;
	logic          pos_found_q;
	rsp_t          rsp_q;
	logic          done_q;

	logic [AW-1:0]    cs [SEGMENTS];
	logic [LEN_W-1:0] cl [SEGMENTS];

	op_t           op;
	logic [IW-1:0] op_idx;
	logic          ld_any;
	logic [IW-1:0] ld_idx;
	logic [AW-1:0] ld_start;
	logic [LEN_W-1:0] ld_len;

	// region reload value
	logic [WW-1:0] rnd, region, lim, rlen;
	always_comb begin
		rnd = ((WW'(cfg_data) + WW'(PAGE - 1)) >> PB) << PB;
		lim = WW'(1) << AW;
		region = (rnd > lim) ? lim : rnd;
		rlen = (region >= WW'(HEADER)) ? region - WW'(HEADER) : '0;
	end

	// scan element
	logic [IW-1:0] sidx;
	logic [AW-1:0] s_start;
	logic [LEN_W-1:0] s_len;
	logic fits, better;
	logic [AW-1:0] fbase;
	assign sidx    = idx_q[IW-1:0];
	assign s_start = cs[sidx];
	assign s_len   = cl[sidx];
	assign fits    = s_len >= req_q.req_size;
	assign fbase   = AW'(req_q.free_addr) - AW'(HEADER);
	always_comb begin
		better = 1'b0;
		if (fits) begin
			if (!found_q) better = 1'b1;
			else if (req_q.fit_style == FIT_BEST) better = s_len < plen_q;
			else if (req_q.fit_style == FIT_WORST) better = s_len > plen_q;
		end
	end

	// split arithmetic on the picked segment
	logic [LEN_W-1:0] left;
	logic [AW-1:0]    p_start;
	assign p_start = cs[pick_q];
	assign left    = plen_q - req_q.req_size;

	// controller
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= CW'(1);
			done_q  <= 1'b0;
			idx_q   <= '0;
			found_q <= 1'b0;
			pos_found_q <= 1'b0;
			pick_q  <= '0;
			plen_q  <= '0;
			pos_q   <= '0;
			rsp_q   <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (cfg_we && cfg_data != '0) cnt_q <= CW'(1);
					if (start) begin
						state_q <= S_SCAN;
						idx_q   <= '0;
						found_q <= 1'b0;
						pos_found_q <= 1'b0;
						pos_q   <= cnt_q;
					end
				end
				S_SCAN: begin
					if (idx_q >= cnt_q) begin
						state_q <= S_UPD;
					end else begin
						idx_q <= idx_q + CW'(1);
						if (req_q.cmd == CMD_ALLOC && better) begin
							found_q <= 1'b1;
							pick_q  <= sidx;
							plen_q  <= s_len;
						end
						if (!pos_found_q && !(s_start < fbase)) begin
							pos_found_q <= 1'b1;
							pos_q <= idx_q;
						end
					end
				end
				S_UPD: begin
					state_q <= S_DONE;
					rsp_q   <= '{grant_addr: '0, status: ST_OK};
					if (req_q.cmd == CMD_ALLOC) begin
						if (req_q.req_size == '0)
							rsp_q.status <= ST_BADARG;
						else if (!found_q)
							rsp_q.status <= ST_NOSPACE;
						else begin
							rsp_q.grant_addr <= OUT_W'(p_start + AW'(HEADER));
							if (left < LEN_W'(HEADER)) cnt_q <= cnt_q - CW'(1);
						end
					end else if (req_q.free_addr >= OUT_W'(HEADER)) begin
						if (cnt_q >= CW'(SEGMENTS)) rsp_q.status <= ST_FULL;
						else cnt_q <= cnt_q + CW'(1);
					end
				end
				S_DONE: begin
					state_q <= S_IDLE;
					done_q  <= 1'b1;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && start) req_q <= req;
	end

	// table command for the cells
	always_comb begin
		op = OP_HOLD; op_idx = '0;
		ld_any = 1'b0; ld_idx = '0; ld_start = '0; ld_len = '0;
		if (state_q == S_IDLE && cfg_we && cfg_data != '0) begin
			ld_any = 1'b1; ld_len = LEN_W'(rlen);
		end else if (state_q == S_UPD) begin
			if (req_q.cmd == CMD_ALLOC) begin
				if (req_q.req_size != '0 && found_q) begin
					if (left >= LEN_W'(HEADER)) begin
						ld_any = 1'b1; ld_idx = pick_q;
						ld_start = p_start + AW'(HEADER) + AW'(req_q.req_size);
						ld_len = left - LEN_W'(HEADER);
					end else begin
						op = OP_SHIFTL; op_idx = pick_q;
					end
				end
			end else if (req_q.free_addr >= OUT_W'(HEADER) && cnt_q < CW'(SEGMENTS)) begin
				op = OP_SHIFTR; op_idx = pos_q[IW-1:0];
				ld_any = 1'b1; ld_idx = pos_q[IW-1:0];
				ld_start = fbase; ld_len = req_q.free_len;
			end
		end
	end

	// chain of cells
	for (genvar g = 0; g < SEGMENTS; g++) begin : g_cell
		localparam int unsigned L = (g == 0) ? 0 : g - 1;
		localparam int unsigned R = (g == SEGMENTS - 1) ? g : g + 1;
		logic from_left;
		// shift right moves cells above the insert point, shift left those from the pick
		assign from_left = (op == OP_SHIFTR) ? (IW'(g) > op_idx) : (IW'(g) < op_idx);
		fsa_cell #(
			.AW     (AW),
			.RST_LEN((g == 0) ? LEN_W'(PAGE - HEADER) : LEN_W'(0))
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.op         (op),
			.load       (ld_any && ld_idx == IW'(g)),
			.from_left  (from_left),
			.new_start  (ld_start),
			.new_len    (ld_len),
			.left_start (cs[L]),
			.left_len   (cl[L]),
			.right_start(cs[R]),
			.right_len  (cl[R]),
			.start_q    (cs[g]),
			.len_q      (cl[g])
		);
	end

	assign busy = state_q != S_IDLE;
	assign done = done_q;
	assign rsp  = rsp_q;
endmodule

@@ hdl/fsa_checker.sv @@
// port-level checks for the free segment allocator
module fsa_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          start,
	input logic          busy,
	input logic          done,
	input fsa_pkg::rsp_t rsp
);
	import fsa_pkg::*;

	// accepted request makes the block busy
	a_take: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy) else $error("request not taken");
	// a result ends the busy period
	a_done: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy) else $error("busy after result");
	// failures never grant an address
	a_fail: assert property (@(posedge clk) disable iff (!arst_n)
		done && rsp.status != ST_OK |-> rsp.grant_addr == '0)
		else $error("address on failure");
	// one strobe per request
	a_once: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("double result");
endmodule

bind free_segment_allocator fsa_checker u_fsa_checker (
	.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .done(done), .rsp(rsp)
);
